>>> src/qpflp_pkg.sv
// Shared types and constants for the QPACK field line parser.
// Holds the request/result structs, phase codes, line kinds and status codes.
package qpflp_pkg;

  localparam int POS_W    = 16;
  localparam int ACC_W    = 17;
  localparam int MAX_CONT = 9;

  localparam logic [ACC_W-1:0] ACC_SAT = 17'h10000;

  localparam logic [3:0] PH_PFX1      = 4'd0;
  localparam logic [3:0] PH_PFX1C     = 4'd1;
  localparam logic [3:0] PH_PFX2      = 4'd2;
  localparam logic [3:0] PH_PFX2C     = 4'd3;
  localparam logic [3:0] PH_LINE      = 4'd4;
  localparam logic [3:0] PH_IDXC      = 4'd5;
  localparam logic [3:0] PH_NLENC     = 4'd6;
  localparam logic [3:0] PH_NSKIP     = 4'd7;
  localparam logic [3:0] PH_VLEN      = 4'd8;
  localparam logic [3:0] PH_VLENC     = 4'd9;
  localparam logic [3:0] PH_VSKIP     = 4'd10;
  localparam logic [3:0] PH_DRAIN     = 4'd11;
  localparam logic [3:0] PH_HALT_LINE = 4'd12;
  localparam logic [3:0] PH_HALT_PFX  = 4'd13;

  localparam logic [1:0] KIND_INDEXED  = 2'd0;
  localparam logic [1:0] KIND_NAME_REF = 2'd1;
  localparam logic [1:0] KIND_LIT_NAME = 2'd2;
  localparam logic [1:0] KIND_END      = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_LINE_BAD = 2'd1;
  localparam logic [1:0] ST_PFX_BAD  = 2'd2;

  localparam logic [7:0] FIELD_LIMIT_RST = 8'd64;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       block_last;
  } in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic             static_ref;
    logic [15:0]      table_index;
    logic [POS_W-1:0] name_offset;
    logic [15:0]      name_length;
    logic             name_huffman;
    logic [POS_W-1:0] value_offset;
    logic [15:0]      value_length;
    logic             value_huffman;
    logic [1:0]       status;
    logic [7:0]       field_count;
    logic             block_end;
  } out_t;

endpackage

>>> src/qpack_field_line_parser.sv
// QPACK field line parser top level: byte-serial section walker and result register.
// Depends on qpflp_pkg for the request/result structs and the phase codes.
//
// Usage: one request per cycle on in_valid/in_ready carries one byte of an
// encoded field section (in_data.byte_in) and a flag marking its final byte.
// The two section prefix integers are skipped; each completed field line
// yields one descriptor on out_valid/out_ready (kind, table index, string
// offsets, lengths and Huffman flags). The final byte of a section always
// yields a result with block_end set, carrying the status of the section.
// cfg_we/cfg_wdata write the field line limit per section.
// A result is registered in the cycle after the request that causes it.
// Throughput: one byte per cycle; all per-byte work is a single pass of
// integer decode and state update ahead of the result register.
// A full result register that is not taken holds in_ready low; a taken
// result frees the register for a new request in the same cycle.
// Reset: synchronous, active low; clears the parse state, empties the result
// register and loads the field limit with 64. Each section end also returns
// the parse state to its reset value.
module qpack_field_line_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  qpflp_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output qpflp_pkg::out_t  out_data,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata
);
  import qpflp_pkg::*;

  logic [7:0]       field_limit_r;
  logic [3:0]       phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [5:0]       shift_r, shift_nxt;
  logic [3:0]       cc_r, cc_nxt;
  logic [1:0]       line_kind_r, line_kind_nxt;
  logic             static_r, static_nxt;
  logic [15:0]      index_r, index_nxt;
  logic [POS_W-1:0] name_start_r, name_start_nxt;
  logic [15:0]      name_size_r, name_size_nxt;
  logic [1:0]       huff_r, huff_nxt;
  logic [POS_W-1:0] value_start_r, value_start_nxt;
  logic [15:0]      skip_r, skip_nxt;
  logic [7:0]       lines_r, lines_nxt;

  logic             out_valid_r;
  out_t             out_data_r;
  out_t             res;
  logic             done;
  logic             emit;
  logic             accept;

  logic [7:0]       b;
  logic [23:0]      cont_sum;
  logic [ACC_W-1:0] cont_acc;
  logic [3:0]       cont_cc;
  logic [5:0]       cont_shift;
  logic             cont_bad;
  logic [3:0]       cc_upd;
  logic [5:0]       shift_upd;
  logic [POS_W-1:0] next_pos;
  logic [1:0]       status_v;

  assign b        = in_data.byte_in;
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign emit     = done || in_data.block_last;

  assign cont_sum   = {7'd0, acc_r} + ({17'd0, b[6:0]} << shift_r[4:0]);
  assign cont_cc    = cc_r + 4'd1;
  assign cont_shift = shift_r + 6'd7;
  assign cont_bad   = b[7] && (cont_cc >= 4'(MAX_CONT));
  assign cc_upd     = b[7] ? cont_cc : cc_r;
  assign shift_upd  = (b[7] && !cont_bad) ? cont_shift : shift_r;
  assign next_pos   = (pos_r == '1) ? pos_r : pos_r + 1'b1;

  always_comb begin
    if (b[6:0] == 7'd0) begin
      cont_acc = acc_r;
    end else if (shift_r < 6'd17) begin
      cont_acc = (cont_sum > {7'd0, ACC_SAT}) ? ACC_SAT : cont_sum[ACC_W-1:0];
    end else begin
      cont_acc = ACC_SAT;
    end
  end

  always_comb begin
    logic [ACC_W-1:0] acc_v;
    logic [15:0]      sat_v;
    phase_nxt       = phase_r;
    acc_nxt         = acc_r;
    shift_nxt       = shift_r;
    cc_nxt          = cc_r;
    line_kind_nxt   = line_kind_r;
    static_nxt      = static_r;
    index_nxt       = index_r;
    name_start_nxt  = name_start_r;
    name_size_nxt   = name_size_r;
    huff_nxt        = huff_r;
    value_start_nxt = value_start_r;
    skip_nxt        = skip_r;
    lines_nxt       = lines_r;
    done            = 1'b0;
    acc_v           = '0;
    sat_v           = '0;
    case (phase_r)
      PH_PFX1: begin
        acc_nxt   = {9'd0, b};
        shift_nxt = '0;
        cc_nxt    = '0;
        phase_nxt = (b != 8'hff) ? PH_PFX2 : PH_PFX1C;
      end
      PH_PFX2: begin
        acc_nxt   = {10'd0, b[6:0]};
        shift_nxt = '0;
        cc_nxt    = '0;
        phase_nxt = (b[6:0] != 7'h7f) ? PH_LINE : PH_PFX2C;
      end
      PH_PFX1C, PH_PFX2C: begin
        acc_nxt   = cont_acc;
        cc_nxt    = cc_upd;
        shift_nxt = shift_upd;
        if (cont_bad) begin
          phase_nxt = PH_HALT_PFX;
        end else if (!b[7]) begin
          phase_nxt = (phase_r == PH_PFX1C) ? PH_PFX2 : PH_LINE;
        end
      end
      PH_LINE: begin
        if (lines_r >= field_limit_r) begin
          phase_nxt = PH_DRAIN;
        end else if (b[7]) begin
          line_kind_nxt = KIND_INDEXED;
          static_nxt    = b[6];
          huff_nxt      = '0;
          acc_nxt       = {11'd0, b[5:0]};
          shift_nxt     = '0;
          cc_nxt        = '0;
          if (b[5:0] != 6'h3f) begin
            index_nxt = {10'd0, b[5:0]};
            done      = 1'b1;
          end else begin
            phase_nxt = PH_IDXC;
          end
        end else if (b[6]) begin
          if (!b[4]) begin
            phase_nxt = PH_HALT_LINE;
          end else begin
            line_kind_nxt = KIND_NAME_REF;
            static_nxt    = 1'b1;
            huff_nxt      = '0;
            acc_nxt       = {13'd0, b[3:0]};
            shift_nxt     = '0;
            cc_nxt        = '0;
            if (b[3:0] != 4'hf) begin
              index_nxt = {12'd0, b[3:0]};
              phase_nxt = PH_VLEN;
            end else begin
              phase_nxt = PH_IDXC;
            end
          end
        end else if (b[5]) begin
          line_kind_nxt = KIND_LIT_NAME;
          static_nxt    = 1'b0;
          index_nxt     = '0;
          huff_nxt      = {1'b0, b[3]};
          acc_nxt       = {14'd0, b[2:0]};
          shift_nxt     = '0;
          cc_nxt        = '0;
          if (b[2:0] != 3'h7) begin
            name_size_nxt  = {13'd0, b[2:0]};
            name_start_nxt = next_pos;
            if (b[2:0] == 3'd0) begin
              phase_nxt = PH_VLEN;
            end else begin
              skip_nxt  = {13'd0, b[2:0]};
              phase_nxt = PH_NSKIP;
            end
          end else begin
            phase_nxt = PH_NLENC;
          end
        end else begin
          phase_nxt = PH_HALT_LINE;
        end
      end
      PH_IDXC: begin
        acc_nxt   = cont_acc;
        cc_nxt    = cc_upd;
        shift_nxt = shift_upd;
        if (cont_bad) begin
          phase_nxt = PH_HALT_LINE;
        end else if (!b[7]) begin
          index_nxt = cont_acc[16] ? 16'hffff : cont_acc[15:0];
          if (line_kind_r == KIND_INDEXED) begin
            done = 1'b1;
          end else begin
            phase_nxt = PH_VLEN;
          end
        end
      end
      PH_NLENC: begin
        acc_nxt   = cont_acc;
        cc_nxt    = cc_upd;
        shift_nxt = shift_upd;
        if (cont_bad) begin
          phase_nxt = PH_HALT_LINE;
        end else if (!b[7]) begin
          sat_v          = cont_acc[16] ? 16'hffff : cont_acc[15:0];
          name_size_nxt  = sat_v;
          name_start_nxt = next_pos;
          if (sat_v == 16'd0) begin
            phase_nxt = PH_VLEN;
          end else begin
            skip_nxt  = sat_v;
            phase_nxt = PH_NSKIP;
          end
        end
      end
      PH_NSKIP: begin
        skip_nxt = skip_r - 16'd1;
        if (skip_r == 16'd1) begin
          phase_nxt = PH_VLEN;
        end
      end
      PH_VLEN, PH_VLENC: begin
        if (phase_r == PH_VLEN) begin
          huff_nxt  = {b[7], huff_r[0]};
          acc_v     = {10'd0, b[6:0]};
          shift_nxt = '0;
          cc_nxt    = '0;
        end else begin
          acc_v     = cont_acc;
          cc_nxt    = cc_upd;
          shift_nxt = shift_upd;
        end
        acc_nxt = acc_v;
        if (phase_r == PH_VLENC && cont_bad) begin
          phase_nxt = PH_HALT_LINE;
        end else if ((phase_r == PH_VLEN && b[6:0] != 7'h7f) ||
                     (phase_r == PH_VLENC && !b[7])) begin
          sat_v           = acc_v[16] ? 16'hffff : acc_v[15:0];
          acc_nxt         = {1'b0, sat_v};
          value_start_nxt = next_pos;
          if (sat_v == 16'd0) begin
            done = 1'b1;
          end else begin
            skip_nxt  = sat_v;
            phase_nxt = PH_VSKIP;
          end
        end else if (phase_r == PH_VLEN) begin
          phase_nxt = PH_VLENC;
        end
      end
      PH_VSKIP: begin
        skip_nxt = skip_r - 16'd1;
        if (skip_r == 16'd1) begin
          done = 1'b1;
        end
      end
      default: begin
      end
    endcase

    pos_nxt = next_pos;
    if (done) begin
      lines_nxt = lines_r + 8'd1;
      phase_nxt = PH_LINE;
    end

    if (phase_nxt inside {PH_PFX1, PH_PFX1C, PH_PFX2, PH_PFX2C, PH_HALT_PFX}) begin
      status_v = ST_PFX_BAD;
    end else if (!(phase_nxt inside {PH_LINE, PH_DRAIN})) begin
      status_v = ST_LINE_BAD;
    end else begin
      status_v = ST_OK;
    end

    res = '0;
    if (done) begin
      res.kind        = line_kind_nxt;
      res.static_ref  = static_nxt;
      res.table_index = index_nxt;
      if (line_kind_nxt == KIND_LIT_NAME) begin
        res.name_offset  = name_start_nxt;
        res.name_length  = name_size_nxt;
        res.name_huffman = huff_nxt[0];
      end
      if (line_kind_nxt != KIND_INDEXED) begin
        res.value_offset  = value_start_nxt;
        res.value_length  = acc_nxt[15:0];
        res.value_huffman = huff_nxt[1];
      end
    end else begin
      res.kind = KIND_END;
    end
    res.field_count = lines_nxt;
    if (in_data.block_last) begin
      res.status      = status_v;
      res.block_end   = 1'b1;
      phase_nxt       = PH_PFX1;
      pos_nxt         = '0;
      acc_nxt         = '0;
      shift_nxt       = '0;
      cc_nxt          = '0;
      line_kind_nxt   = '0;
      static_nxt      = 1'b0;
      index_nxt       = '0;
      name_start_nxt  = '0;
      name_size_nxt   = '0;
      huff_nxt        = '0;
      value_start_nxt = '0;
      skip_nxt        = '0;
      lines_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_limit_r <= FIELD_LIMIT_RST;
      phase_r       <= PH_PFX1;
      pos_r         <= '0;
      acc_r         <= '0;
      shift_r       <= '0;
      cc_r          <= '0;
      line_kind_r   <= '0;
      static_r      <= 1'b0;
      index_r       <= '0;
      name_start_r  <= '0;
      name_size_r   <= '0;
      huff_r        <= '0;
      value_start_r <= '0;
      skip_r        <= '0;
      lines_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        field_limit_r <= cfg_wdata;
      end
      if (accept) begin
        phase_r       <= phase_nxt;
        pos_r         <= pos_nxt;
        acc_r         <= acc_nxt;
        shift_r       <= shift_nxt;
        cc_r          <= cc_nxt;
        line_kind_r   <= line_kind_nxt;
        static_r      <= static_nxt;
        index_r       <= index_nxt;
        name_start_r  <= name_start_nxt;
        name_size_r   <= name_size_nxt;
        huff_r        <= huff_nxt;
        value_start_r <= value_start_nxt;
        skip_r        <= skip_nxt;
        lines_r       <= lines_nxt;
      end
      if (accept && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.block_last |=> phase_r == PH_PFX1 && lines_r == 8'd0 && pos_r == '0)
    else $error("section end did not return parse state to reset");

  a_status_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != ST_OK |-> out_data_r.block_end)
    else $error("nonzero status on a result that is not the section end");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_data.block_last &&
    (phase_r == PH_DRAIN || phase_r == PH_HALT_LINE || phase_r == PH_HALT_PFX) |-> !emit)
    else $error("result raised after parsing stopped");

  a_end_only_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.kind == KIND_END |->
    out_data_r.table_index == 16'd0 && out_data_r.value_length == 16'd0 &&
    out_data_r.name_length == 16'd0 && out_data_r.block_end)
    else $error("end-only result carries descriptor data");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("pending result dropped while receiver stalled");

endmodule

>>> bench/qpflp_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the QPACK field line parser: follows the section decode per request,
// predicts each field descriptor and compares it with the result channel.
// Depends on qpflp_pkg for the request/result structs, phase, kind and status codes.
module qpflp_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  qpflp_pkg::in_t  in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  qpflp_pkg::out_t out_data,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata,
  output int              mismatches,
  output int              pending
);
  import qpflp_pkg::*;

  logic [7:0]       field_limit;
  logic [3:0]       phase;
  logic [15:0]      byte_pos;
  logic [ACC_W-1:0] accum;
  logic [5:0]       shift;
  logic [3:0]       cont_count;
  logic [1:0]       line_kind;
  logic             static_flag;
  logic [15:0]      index_hold;
  logic [15:0]      name_start;
  logic [15:0]      name_size;
  logic [1:0]       huff;
  logic [15:0]      value_start;
  logic [15:0]      skip_left;
  logic [7:0]       lines;

  out_t expected_descriptors[$];

  function automatic logic [15:0] sat16(input logic [31:0] v);
    return (v > 32'd65535) ? 16'hffff : v[15:0];
  endfunction

  function automatic void clear_section();
    phase       = PH_PFX1;
    byte_pos    = '0;
    accum       = '0;
    shift       = '0;
    cont_count  = '0;
    line_kind   = '0;
    static_flag = 1'b0;
    index_hold  = '0;
    name_start  = '0;
    name_size   = '0;
    huff        = '0;
    value_start = '0;
    skip_left   = '0;
    lines       = '0;
  endfunction

  function automatic logic int_first(input logic [7:0] b, input logic [7:0] mask);
    accum      = {9'd0, b & mask};
    shift      = '0;
    cont_count = '0;
    return accum < {9'd0, mask};
  endfunction

  // 1 done, 0 more bytes, -1 too many continuation bytes
  function automatic int int_next(input logic [7:0] b);
    logic [63:0] sum;
    sum = 64'd0;
    if (b[6:0] != 7'd0) begin
      if (shift < 6'd17) begin
        sum   = {47'd0, accum} + ({57'd0, b[6:0]} << shift);
        accum = (sum > 64'h10000) ? ACC_SAT : sum[ACC_W-1:0];
      end else begin
        accum = ACC_SAT;
      end
    end
    if (!b[7]) return 1;
    cont_count = cont_count + 4'd1;
    if (cont_count >= 4'(MAX_CONT)) return -1;
    shift = shift + 6'd7;
    return 0;
  endfunction

  function automatic void take_name_size();
    name_size  = sat16({15'd0, accum});
    name_start = sat16({16'd0, byte_pos} + 32'd1);
    if (name_size == 16'd0) begin
      phase = PH_VLEN;
    end else begin
      skip_left = name_size;
      phase     = PH_NSKIP;
    end
  endfunction

  function automatic logic take_value_len();
    accum       = {1'b0, sat16({15'd0, accum})};
    value_start = sat16({16'd0, byte_pos} + 32'd1);
    if (accum == '0) return 1'b1;
    skip_left = accum[15:0];
    phase     = PH_VSKIP;
    return 1'b0;
  endfunction

  task automatic decode_section_byte(input in_t req);
    logic [7:0] b;
    logic       done;
    int         r;
    out_t       d;
    b    = req.byte_in;
    done = 1'b0;
    case (phase)
      PH_PFX1: phase = int_first(b, 8'hff) ? PH_PFX2 : PH_PFX1C;
      PH_PFX1C: begin
        r = int_next(b);
        if (r < 0) phase = PH_HALT_PFX;
        else if (r > 0) phase = PH_PFX2;
      end
      PH_PFX2: phase = int_first(b, 8'h7f) ? PH_LINE : PH_PFX2C;
      PH_PFX2C: begin
        r = int_next(b);
        if (r < 0) phase = PH_HALT_PFX;
        else if (r > 0) phase = PH_LINE;
      end
      PH_LINE: begin
        if (lines >= field_limit) begin
          phase = PH_DRAIN;
        end else if (b[7]) begin
          line_kind   = KIND_INDEXED;
          static_flag = b[6];
          huff        = 2'b00;
          if (int_first(b, 8'h3f)) begin
            index_hold = sat16({15'd0, accum});
            done       = 1'b1;
          end else begin
            phase = PH_IDXC;
          end
        end else if (b[7:6] == 2'b01) begin
          if (!b[4]) begin
            phase = PH_HALT_LINE;
          end else begin
            line_kind   = KIND_NAME_REF;
            static_flag = 1'b1;
            huff        = 2'b00;
            if (int_first(b, 8'h0f)) begin
              index_hold = sat16({15'd0, accum});
              phase      = PH_VLEN;
            end else begin
              phase = PH_IDXC;
            end
          end
        end else if (b[7:5] == 3'b001) begin
          line_kind   = KIND_LIT_NAME;
          static_flag = 1'b0;
          index_hold  = '0;
          huff        = {1'b0, b[3]};
          if (int_first(b, 8'h07)) take_name_size();
          else phase = PH_NLENC;
        end else begin
          phase = PH_HALT_LINE;
        end
      end
      PH_IDXC: begin
        r = int_next(b);
        if (r < 0) begin
          phase = PH_HALT_LINE;
        end else if (r > 0) begin
          index_hold = sat16({15'd0, accum});
          if (line_kind == KIND_INDEXED) done = 1'b1;
          else phase = PH_VLEN;
        end
      end
      PH_NLENC: begin
        r = int_next(b);
        if (r < 0) phase = PH_HALT_LINE;
        else if (r > 0) take_name_size();
      end
      PH_NSKIP: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 16'd0) phase = PH_VLEN;
      end
      PH_VLEN: begin
        huff[1] = b[7];
        if (int_first(b, 8'h7f)) done = take_value_len();
        else phase = PH_VLENC;
      end
      PH_VLENC: begin
        r = int_next(b);
        if (r < 0) phase = PH_HALT_LINE;
        else if (r > 0) done = take_value_len();
      end
      PH_VSKIP: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 16'd0) done = 1'b1;
      end
      default: ;
    endcase

    if (byte_pos != 16'hffff) byte_pos = byte_pos + 16'd1;

    d = '0;
    if (done) begin
      lines        = lines + 8'd1;
      phase        = PH_LINE;
      d.kind       = line_kind;
      d.static_ref = static_flag;
      d.table_index = index_hold;
      if (line_kind == KIND_LIT_NAME) begin
        d.name_offset  = name_start;
        d.name_length  = name_size;
        d.name_huffman = huff[0];
      end
      if (line_kind != KIND_INDEXED) begin
        d.value_offset  = value_start;
        d.value_length  = accum[15:0];
        d.value_huffman = huff[1];
      end
    end else begin
      d.kind = KIND_END;
    end

    if (done || req.block_last) begin
      d.field_count = lines;
      if (req.block_last) begin
        case (phase)
          PH_PFX1, PH_PFX1C, PH_PFX2, PH_PFX2C, PH_HALT_PFX: d.status = ST_PFX_BAD;
          PH_LINE, PH_DRAIN: d.status = ST_OK;
          default: d.status = ST_LINE_BAD;
        endcase
        d.block_end = 1'b1;
        clear_section();
      end
      expected_descriptors.push_back(d);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_descriptor(input out_t got);
    out_t want;
    if (expected_descriptors.size() == 0) begin
      $error("result with no request pending: kind %0d field_count %0d",
             got.kind, got.field_count);
      mismatches++;
    end else begin
      want = expected_descriptors.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("static_ref", want.static_ref, got.static_ref);
      check_field("table_index", want.table_index, got.table_index);
      check_field("name_offset", want.name_offset, got.name_offset);
      check_field("name_length", want.name_length, got.name_length);
      check_field("name_huffman", want.name_huffman, got.name_huffman);
      check_field("value_offset", want.value_offset, got.value_offset);
      check_field("value_length", want.value_length, got.value_length);
      check_field("value_huffman", want.value_huffman, got.value_huffman);
      check_field("status", want.status, got.status);
      check_field("field_count", want.field_count, got.field_count);
      check_field("block_end", want.block_end, got.block_end);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      field_limit = FIELD_LIMIT_RST;
      mismatches  = 0;
      clear_section();
      expected_descriptors.delete();
    end else begin
      if (out_valid && out_ready) compare_descriptor(out_data);
      if (cfg_we) field_limit = cfg_wdata;
      if (in_valid && in_ready) decode_section_byte(in_data);
    end
    pending = expected_descriptors.size();
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Top of the QPACK field line parser bench: clock, reset, section stimulus and verdict.
// Depends on qpflp_pkg, the parser top level and the qpflp_checker scoreboard.
module testbench;
  import qpflp_pkg::*;

  localparam int STALL_LIMIT = 1000;

  localparam logic [7:0] OP_INDEXED  = 8'h80;
  localparam logic [7:0] OP_NAME_REF = 8'h40;
  localparam logic [7:0] OP_LIT_NAME = 8'h20;
  localparam logic [7:0] STATIC_BIT  = 8'h40;
  localparam logic [7:0] REF_STATIC  = 8'h10;
  localparam logic [7:0] HUFF_BIT    = 8'h80;
  localparam logic [7:0] NAME_HUFF   = 8'h08;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_we;
  logic [7:0] cfg_wdata;
  logic calm;
  int   mismatches;
  int   pending;
  int   idle_cycles;

  logic [7:0] section_bytes[$];

  qpack_field_line_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  qpflp_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_int();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 20);
    if (r < 85) return $urandom_range(21, 300);
    if (r < 95) return $urandom_range(301, 70000);
    return $urandom;
  endfunction

  function automatic int pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 6);
    if (r < 95) return $urandom_range(7, 30);
    return $urandom_range(31, 200);
  endfunction

  function automatic int pick_pad();
    if ($urandom_range(0, 99) < 88) return 0;
    return $urandom_range(1, 8);
  endfunction

  // pad > 0 stretches an integer that overflows its prefix with zero continuation groups
  task automatic put_int(input logic [7:0] flags, input int nbits,
                         input int unsigned value, input int pad);
    logic [63:0] lim;
    logic [63:0] rest;
    int k;
    lim = (64'd1 << nbits) - 64'd1;
    rest = {32'd0, value};
    if (rest < lim) begin
      section_bytes.push_back(flags | rest[7:0]);
    end else begin
      section_bytes.push_back(flags | lim[7:0]);
      rest = rest - lim;
      while (rest >= 64'd128) begin
        section_bytes.push_back(8'h80 | {1'b0, rest[6:0]});
        rest = rest >> 7;
      end
      if (pad > 0) begin
        section_bytes.push_back(8'h80 | {1'b0, rest[6:0]});
        for (k = 1; k < pad; k++) section_bytes.push_back(8'h80);
        section_bytes.push_back(8'h00);
      end else begin
        section_bytes.push_back({1'b0, rest[6:0]});
      end
    end
  endtask

  task automatic put_bytes(input int n);
    logic [7:0] rb;
    repeat (n) begin
      rb = 8'($urandom);
      section_bytes.push_back(rb);
    end
  endtask

  task automatic put_zero_prefix();
    put_int(8'h00, 8, 0, 0);
    put_int(8'h00, 7, 0, 0);
  endtask

  task automatic put_string();
    logic [7:0] rb;
    int len;
    rb = 8'($urandom);
    len = pick_len();
    put_int(rb & HUFF_BIT, 7, len, pick_pad());
    put_bytes(len);
  endtask

  task automatic put_line();
    logic [7:0] rb;
    int len;
    rb = 8'($urandom);
    case ($urandom_range(0, 2))
      0: put_int(OP_INDEXED | (rb & STATIC_BIT), 6, pick_int(), pick_pad());
      1: begin
        put_int(OP_NAME_REF | REF_STATIC | (rb & 8'h20), 4, pick_int(), pick_pad());
        put_string();
      end
      default: begin
        len = pick_len();
        put_int(OP_LIT_NAME | (rb & 8'h18), 3, len, pick_pad());
        put_bytes(len);
        put_string();
      end
    endcase
  endtask

  task automatic build_random_section();
    logic [7:0] rb;
    int n;
    int drop;
    rb = 8'($urandom);
    section_bytes.delete();
    put_int(8'h00, 8, pick_int(), pick_pad());
    put_int(rb & 8'h80, 7, pick_int(), pick_pad());
    n = $urandom_range(0, 6);
    repeat (n) put_line();
    if ($urandom_range(0, 99) < 30) begin
      rb = 8'($urandom);
      case ($urandom_range(0, 6))
        0: begin
          if (section_bytes.size() > 1) begin
            drop = $urandom_range(1, section_bytes.size() - 1);
            repeat (drop) void'(section_bytes.pop_back());
          end
        end
        1: begin
          section_bytes.push_back(OP_NAME_REF | (rb & 8'h2f));
          put_bytes($urandom_range(0, 4));
        end
        2: begin
          section_bytes.push_back(rb & 8'h1f);
          put_bytes($urandom_range(0, 4));
        end
        3: begin
          put_int(OP_INDEXED | (rb & STATIC_BIT), 6, $urandom_range(63, 5000),
                  $urandom_range(9, 11));
          put_bytes($urandom_range(0, 4));
        end
        4: begin
          put_int(OP_NAME_REF | REF_STATIC, 4, $urandom_range(0, 15), 0);
          put_int(rb & HUFF_BIT, 7, $urandom_range(65535, 400000), 0);
          put_bytes($urandom_range(0, 5));
        end
        5: begin
          section_bytes.delete();
          put_bytes($urandom_range(1, 12));
        end
        default: begin
          section_bytes.delete();
          if (rb[0]) begin
            put_bytes($urandom_range(1, 2));
          end else begin
            put_int(8'h00, 8, $urandom_range(255, 5000), $urandom_range(9, 10));
            put_bytes($urandom_range(0, 3));
          end
        end
      endcase
    end
  endtask

  // hold the request until accepted, then return on the next falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{byte_in: b, block_last: last};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_section();
    int i;
    for (i = 0; i < section_bytes.size(); i++)
      send_byte(section_bytes[i], i == section_bytes.size() - 1);
    section_bytes.delete();
  endtask

  task automatic set_limit(input logic [7:0] v);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int hold;
    out_ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        if (calm || $urandom_range(0, 2) != 0) begin
          out_ready <= 1'b1;
          hold = calm ? 1 : $urandom_range(1, 10);
        end else begin
          out_ready <= 1'b0;
          hold = pick_gap() + 1;
        end
      end
      hold--;
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin
    logic [7:0] phase_limits [8];
    logic [7:0] rb;
    int random_items;
    int target;
    int p;
    int i;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    calm      = 1'b0;
    random_items = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // truncated prefix
    section_bytes.push_back(8'h00);
    send_section();
    // empty section
    put_zero_prefix();
    send_section();
    // prefix and line integers at their prefix boundaries, line ends on last byte
    put_int(8'h00, 8, 255, 0);
    put_int(8'h80, 7, 127, 0);
    put_int(OP_INDEXED | STATIC_BIT, 6, 63, 0);
    put_int(OP_INDEXED, 6, 0, 0);
    put_int(OP_NAME_REF | REF_STATIC | 8'h20, 4, 15, 0);
    put_int(HUFF_BIT, 7, 2, 0);
    section_bytes.push_back(8'hff);
    section_bytes.push_back(8'h00);
    put_int(OP_LIT_NAME | NAME_HUFF, 3, 7, 0);
    put_bytes(7);
    put_int(8'h00, 7, 0, 0);
    send_section();
    // saturated index, longest legal continuation, empty literal name
    put_zero_prefix();
    put_int(OP_INDEXED | STATIC_BIT, 6, 70000, 0);
    put_int(OP_NAME_REF | REF_STATIC, 4, 20, 8);
    put_int(8'h00, 7, 1, 0);
    section_bytes.push_back(8'h41);
    put_int(OP_LIT_NAME, 3, 0, 0);
    put_int(8'h00, 7, 0, 0);
    send_section();
    // dynamic name reference
    put_zero_prefix();
    section_bytes.push_back(OP_NAME_REF | 8'h05);
    put_bytes(2);
    send_section();
    // post-base form
    put_zero_prefix();
    section_bytes.push_back(8'h10);
    section_bytes.push_back(8'h01);
    send_section();
    // one continuation byte too many in a line and in the prefix
    put_zero_prefix();
    put_int(OP_INDEXED, 6, 100, 9);
    send_section();
    put_int(8'h00, 8, 300, 9);
    section_bytes.push_back(8'h00);
    send_section();
    // section ends inside a name and inside a saturated value skip
    put_zero_prefix();
    put_int(OP_LIT_NAME, 3, 3, 0);
    put_bytes(1);
    send_section();
    put_zero_prefix();
    put_int(OP_NAME_REF | REF_STATIC, 4, 2, 0);
    put_int(HUFF_BIT, 7, 100000, 0);
    put_bytes(2);
    send_section();
    // field limit reached
    set_limit(8'd1);
    put_zero_prefix();
    repeat (3) put_int(OP_INDEXED | STATIC_BIT, 6, 5, 0);
    send_section();

    phase_limits[0] = 8'd255;
    phase_limits[1] = 8'd1;
    phase_limits[2] = 8'd2;
    phase_limits[3] = 8'd3;
    phase_limits[4] = FIELD_LIMIT_RST;
    phase_limits[5] = 8'($urandom_range(1, 255));
    phase_limits[6] = 8'($urandom_range(4, 8));
    phase_limits[7] = 8'($urandom_range(1, 255));
    for (p = 0; p < 8; p++) begin
      set_limit(phase_limits[p]);
      target = random_items + 65;
      while (random_items < target) begin
        calm = ($urandom_range(0, 7) == 0);
        build_random_section();
        random_items += section_bytes.size();
        send_section();
      end
    end
    calm = 1'b0;

    // limit at its top, then more field lines than it allows
    set_limit(8'd255);
    put_zero_prefix();
    for (i = 0; i < 258; i++) begin
      rb = 8'($urandom_range(0, 62));
      section_bytes.push_back(OP_INDEXED | rb);
    end
    send_section();

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

>>> qpack_field_line_parser.f
src/qpflp_pkg.sv
src/qpack_field_line_parser.sv
bench/qpflp_checker.sv
bench/testbench.sv
